// ===== rtl/core/ita_pkg.sv =====
package ita_pkg;

   localparam int FUNC_W      = 3;
   localparam int INDEX_W     = 9;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 2;
   localparam int MAX_ENTRIES = 512;
   localparam int ROW_BITS    = 32;
   localparam int COL_W       = 5;
   localparam int ROW_W       = INDEX_W - COL_W;
   localparam int ROW_MAX     = 1 << ROW_W;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY      = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_STORE   = 3'd0,
      FUNC_GET     = 3'd1,
      FUNC_IS_USED = 3'd2,
      FUNC_ALLOC   = 3'd3,
      FUNC_FREE    = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_READ2,
      S_EVAL2,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                en;
      logic [ROW_W-1:0]    row;
      logic [ROW_BITS-1:0] data;
   } mark_wr_type;

   function automatic logic [COL_W-1:0] lowest_set(input logic [ROW_BITS-1:0] vec);
      logic [ROW_BITS-1:0] iso;
      logic [COL_W-1:0]    pos;
      iso = vec & (~vec + ROW_BITS'(1));
      pos = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         pos = pos | (iso[i] ? COL_W'(i) : COL_W'(0));
      end
      return pos;
   endfunction

endpackage

// ===== rtl/core/ita_mark_ram.sv =====
module ita_mark_ram
   import ita_pkg::*;
#(
   parameter int ENTRIES = MAX_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ROW_W-1:0]    rd_row,
   input  mark_wr_type         wr,
   output logic [ROW_BITS-1:0] rd_data,
   output logic [ROW_MAX-1:0]  row_full
);

   localparam int ROWS      = (ENTRIES + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_DEPTH = 1 << ROW_AW;

   logic [ROW_BITS-1:0]  mem [ROW_DEPTH];
   logic [ROW_BITS-1:0]  raw_q_ff;
   logic                 rd_valid_ff;
   logic [ROW_DEPTH-1:0] row_valid_ff;
   logic [ROW_MAX-1:0]   row_full_ff;
   logic [ROW_MAX-1:0]   full_init;
   logic [ROW_BITS-1:0]  absent;
   logic [ROW_AW-1:0]    rd_addr;
   logic [ROW_AW-1:0]    wr_addr;

   assign rd_addr = rd_row[ROW_AW-1:0];
   assign wr_addr = wr.row[ROW_AW-1:0];

   // columns past the table end count as taken
   always_comb begin
      for (int c = 0; c < ROW_BITS; c++) begin
         absent[c] = ({1'b0, wr.row, COL_W'(c)} >= 10'(ENTRIES));
      end
      for (int r = 0; r < ROW_MAX; r++) begin
         full_init[r] = (r >= ROWS);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
      raw_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         row_full_ff  <= full_init;
      end else begin
         rd_valid_ff <= row_valid_ff[rd_addr];
         if (wr.en) begin
            row_valid_ff[wr_addr] <= 1'b1;
            row_full_ff[wr.row]   <= &(wr.data | absent);
         end
      end
   end

   assign rd_data  = rd_valid_ff ? raw_q_ff : '0;
   assign row_full = row_full_ff;

endmodule

// ===== rtl/core/index_table_with_id_allocator.sv =====
// channel  | direction | handshake        | beat fields
// req      | in        | req_valid/stall  | func, index, value, limit
// rsp      | out       | rsp_valid/stall  | status, read_value, is_used, found_index
//
// one beat in flight: the core steps through the eval and result states, with read2 and eval2
// between them for an allocate that needs a second mark-row read (no free slot in the
// window of its start row). the next beat is accepted once the current result sits in
// the rsp register.
// reset is synchronous; marks read as free afterwards through per-row valid bits,
// with no clearing pass. the value table holds nothing defined until written.
// a stalled rsp holds its beat; the core waits in its result state meanwhile.
module index_table_with_id_allocator
   import ita_pkg::*;
#(
   parameter int TABLE_ENTRIES = MAX_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [INDEX_W-1:0]  req_limit,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic                rsp_is_used,
   output logic [INDEX_W-1:0]  rsp_found_index
);

   localparam int ENTRY_COUNT = (TABLE_ENTRIES < MAX_ENTRIES) ? TABLE_ENTRIES : MAX_ENTRIES;
   localparam int VAW         = $clog2(ENTRY_COUNT);

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]   func_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [INDEX_W-1:0]  limit_ff;
   logic [ROW_W-1:0]    srch_row_ff, srch_row_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [VALUE_W-1:0]  res_read_ff, res_read_in;
   logic                res_used_ff, res_used_in;
   logic [INDEX_W-1:0]  res_found_ff, res_found_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_read_ff;
   logic                rsp_used_ff;
   logic [INDEX_W-1:0]  rsp_found_ff;

   logic [VALUE_W-1:0]  vmem [ENTRY_COUNT];
   logic [VALUE_W-1:0]  val_q_ff;
   logic                vmem_we;
   logic [INDEX_W-1:0]  vmem_waddr;
   logic [VALUE_W-1:0]  vmem_wdata;

   mark_wr_type         mark_wr;
   logic [ROW_W-1:0]    mark_rd_row;
   logic [ROW_BITS-1:0] mark_row;
   logic [ROW_MAX-1:0]  row_full;

   logic                req_accept;
   logic                out_load;
   logic                in_range;
   logic                mark;
   logic [ROW_W-1:0]    row;
   logic [COL_W-1:0]    col;
   logic [INDEX_W-1:0]  top_raw;
   logic [INDEX_W-1:0]  top;
   logic [ROW_W-1:0]    top_row;
   logic [COL_W-1:0]    top_col;
   logic [ROW_BITS-1:0] win1, win2, free1, free2;
   logic [COL_W-1:0]    pos1, pos2, cand_pos;
   logic [ROW_MAX-1:0]  cand;
   logic                hit1, hit2, hit_row;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_load   = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   ita_mark_ram #(
      .ENTRIES (ENTRY_COUNT)
   ) u_marks (
      .clock    (clock),
      .reset    (reset),
      .rd_row   (mark_rd_row),
      .wr       (mark_wr),
      .rd_data  (mark_row),
      .row_full (row_full)
   );

   assign mark_rd_row = (state_ff == S_IDLE) ? req_index[INDEX_W-1:COL_W] : srch_row_ff;

   always_ff @(posedge clock) begin
      if (vmem_we) begin
         vmem[vmem_waddr[VAW-1:0]] <= vmem_wdata;
      end
      if (state_ff == S_IDLE) begin
         val_q_ff <= vmem[req_index[VAW-1:0]];
      end
   end

   // decode of the captured beat
   always_comb begin
      in_range = ({1'b0, index_ff} < 10'(ENTRY_COUNT));
      row      = index_ff[INDEX_W-1:COL_W];
      col      = index_ff[COL_W-1:0];
      mark     = in_range && mark_row[col];
      top_raw  = (limit_ff == '0) ? INDEX_W'(ENTRY_COUNT - 1) : limit_ff;
      top      = (top_raw > INDEX_W'(ENTRY_COUNT - 1)) ? INDEX_W'(ENTRY_COUNT - 1) : top_raw;
      top_row  = top[INDEX_W-1:COL_W];
      top_col  = top[COL_W-1:0];
      for (int c = 0; c < ROW_BITS; c++) begin
         win1[c] = (COL_W'(c) >= col) && ((row != top_row) || (COL_W'(c) <= top_col));
         win2[c] = (srch_row_ff != top_row) || (COL_W'(c) <= top_col);
      end
      for (int r = 0; r < ROW_MAX; r++) begin
         cand[r] = (ROW_W'(r) > row) && (ROW_W'(r) <= top_row) && !row_full[r];
      end
      free1    = ~mark_row & win1;
      free2    = ~mark_row & win2;
      hit1     = |free1;
      hit2     = |free2;
      hit_row  = |cand;
      pos1     = lowest_set(free1);
      pos2     = lowest_set(free2);
      cand_pos = lowest_set({{(ROW_BITS - ROW_MAX){1'b0}}, cand});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if ((func_ff == FUNC_ALLOC) && (index_ff <= top) && !hit1 && hit_row) begin
               state_in = S_READ2;
            end else begin
               state_in = S_RESP;
            end
         end
         S_READ2: state_in = S_EVAL2;
         S_EVAL2: state_in = S_RESP;
         S_RESP: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_used_in   = res_used_ff;
      res_found_in  = res_found_ff;
      srch_row_in   = srch_row_ff;
      mark_wr.en    = 1'b0;
      mark_wr.row   = row;
      mark_wr.data  = mark_row;
      vmem_we       = 1'b0;
      vmem_waddr    = index_ff;
      vmem_wdata    = value_ff;
      unique case (state_ff)
         S_EVAL: begin
            res_status_in = ST_NOT_FOUND;
            res_read_in   = '0;
            res_used_in   = 1'b0;
            res_found_in  = '0;
            unique case (func_ff)
               FUNC_STORE: begin
                  if (in_range) begin
                     res_status_in = ST_OK;
                     res_read_in   = mark ? val_q_ff : '0;
                     res_used_in   = mark;
                     mark_wr.en    = 1'b1;
                     mark_wr.data  = mark_row | (ROW_BITS'(1) << col);
                     vmem_we       = 1'b1;
                  end
               end
               FUNC_GET: begin
                  if (mark) begin
                     res_status_in = ST_OK;
                     res_read_in   = val_q_ff;
                     res_used_in   = 1'b1;
                  end
               end
               FUNC_IS_USED: begin
                  res_status_in = ST_OK;
                  res_used_in   = mark;
               end
               FUNC_ALLOC: begin
                  res_status_in = ST_BUSY;
                  if (index_ff <= top) begin
                     if (hit1) begin
                        res_status_in = ST_OK;
                        res_found_in  = {row, pos1};
                        mark_wr.en    = 1'b1;
                        mark_wr.data  = mark_row | (ROW_BITS'(1) << pos1);
                        vmem_we       = 1'b1;
                        vmem_waddr    = {row, pos1};
                     end else if (hit_row) begin
                        srch_row_in = cand_pos[ROW_W-1:0];
                     end
                  end
               end
               FUNC_FREE: begin
                  if (in_range) begin
                     res_status_in = ST_OK;
                     res_used_in   = mark;
                     mark_wr.en    = 1'b1;
                     mark_wr.data  = mark_row & ~(ROW_BITS'(1) << col);
                     vmem_we       = 1'b1;
                     vmem_wdata    = '0;
                  end
               end
               default: ;
            endcase
         end
         S_EVAL2: begin
            mark_wr.row = srch_row_ff;
            if (hit2) begin
               res_status_in = ST_OK;
               res_found_in  = {srch_row_ff, pos2};
               mark_wr.en    = 1'b1;
               mark_wr.data  = mark_row | (ROW_BITS'(1) << pos2);
               vmem_we       = 1'b1;
               vmem_waddr    = {srch_row_ff, pos2};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff  <= req_func;
         index_ff <= req_index;
         value_ff <= req_value;
         limit_ff <= req_limit;
      end
      srch_row_ff   <= srch_row_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_used_ff   <= res_used_in;
      res_found_ff  <= res_found_in;
      if (out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_read_ff   <= res_read_ff;
         rsp_used_ff   <= res_used_ff;
         rsp_found_ff  <= res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_is_used     = rsp_used_ff;
   assign rsp_found_index = rsp_found_ff;

`ifndef SYNTH
   a_alloc_in_window: assert property (@(posedge clock) disable iff (reset)
      (out_load && (func_ff == FUNC_ALLOC) && (res_status_ff == ST_OK))
         |-> (res_found_ff >= index_ff) && (res_found_ff <= top))
      else $error("allocated index outside the search window");

   a_found_only_alloc: assert property (@(posedge clock) disable iff (reset)
      (out_load && (func_ff != FUNC_ALLOC)) |-> (res_found_ff == '0))
      else $error("found index set on a non-allocate beat");

   a_get_ok_used: assert property (@(posedge clock) disable iff (reset)
      (out_load && (func_ff == FUNC_GET) && (res_status_ff == ST_OK)) |-> res_used_ff)
      else $error("get succeeded on an unused index");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("rsp valid raised outside the result state");
`endif

endmodule
